[design/qtp_pkg.sv]
// qtp_pkg: types, constants and helper functions of the quintic trajectory planner
// used by qtp_serial_mul, qtp_core and quintic_trajectory_planner
package qtp_pkg;

  localparam int unsigned AccW      = 128;
  localparam int unsigned DataW     = 32;
  localparam int unsigned MulBits   = 32;
  localparam logic [31:0] MinDuration = 32'd66;

  typedef enum logic {
    OP_PLAN   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_VEL  = 2'd0,
    CFG_ACC  = 2'd1,
    CFG_JERK = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PLAN, ST_PV, ST_PVR, ST_PA, ST_PAR, ST_PJ, ST_PJR,
    ST_PF, ST_P1R, ST_P2, ST_P2R, ST_SAMP, ST_SG, ST_SP1, ST_SP2,
    ST_SP3, ST_SP4, ST_SV1, ST_SV2, ST_SV3, ST_SV4, ST_SV5, ST_SA1,
    ST_SA2, ST_SA3, ST_SA4, ST_SA5, ST_MW, ST_FTRY, ST_FMW, ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] ref_acceleration;
    logic [31:0] ref_velocity;
    logic [31:0] ref_position;
    logic [31:0] peak_acceleration;
    logic [31:0] peak_velocity;
    logic [31:0] move_duration;
  } result_t;

  // magnitude of a signed word
  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // constant multiplies as shift and add
  function automatic logic [35:0] mul15(input logic [31:0] m);
    return ({4'd0, m} << 4) - {4'd0, m};
  endfunction

  function automatic logic [36:0] mul30(input logic [31:0] m);
    return ({5'd0, m} << 5) - ({5'd0, m} << 1);
  endfunction

  function automatic logic [37:0] mul60(input logic [31:0] m);
    return ({6'd0, m} << 6) - ({6'd0, m} << 2);
  endfunction

  // 378372 = bits 2, 9, 10, 14, 15, 16, 18
  function automatic logic [50:0] mul_ka(input logic [31:0] m);
    logic [50:0] e;
    e = {19'd0, m};
    return (e << 2) + (e << 9) + (e << 10) + (e << 14) + (e << 15) + (e << 16) + (e << 18);
  endfunction

  // clamp a magnitude to the signed 32-bit range and apply the sign
  function automatic logic [31:0] sat_signed(input logic [47:0] mag, input logic neg);
    logic [31:0] m;
    m = 32'h8000_0000;
    if (!neg) begin
      return (mag > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    if (mag <= 48'h8000_0000) begin
      m = mag[31:0];
    end
    return 32'd0 - m;
  endfunction

endpackage

[design/qtp_serial_mul.sv]
// qtp_serial_mul: bit-serial shift-add multiplier, 128-bit operand by 32-bit operand
// depends on qtp_pkg
module qtp_serial_mul import qtp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AccW-1:0] a_i,
  input  logic [MulBits-1:0] m_i,
  output logic            done_o,
  output logic [AccW-1:0] res_o
);

  logic [AccW-1:0]    acc_q, a_q;
  logic [MulBits-1:0] m_q;
  logic [5:0]         cnt_q;
  logic               busy_q;

  // control: one multiplier bit per cycle, msb first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'(MulBits);
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      m_q   <= m_i;
    end else if (busy_q && cnt_q != 6'd0) begin
      acc_q <= (acc_q << 1) + (m_q[MulBits-1] ? a_q : '0);
      m_q   <= m_q << 1;
    end
  end

  assign done_o = busy_q && (cnt_q == 6'd0);
  assign res_o  = acc_q;

endmodule

[design/qtp_core.sv]
// qtp_core: sequencer of the planner, bounds search by trial multiplication and
// sampling of the quintic profile; depends on qtp_pkg and qtp_serial_mul
module qtp_core import qtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start_i,
  input  logic        opcode_i,
  input  logic [31:0] move_distance_i,
  input  logic [16:0] norm_time_i,
  input  logic        out_free_i,
  output logic        idle_o,
  output logic        done_o,
  output result_t     res_o
);

  state_e state_q, state_d, ret_q, ret_d;
  logic [31:0] vel_q, acc_q, jerk_q;
  logic [31:0] sdist_q, sdist_d, sdur_q, sdur_d;
  logic [31:0] dist_q, dist_d, mag_q, mag_d, t_q, t_d, x_q, x_d;
  logic        neg_q, neg_d;
  logic [16:0] tau_q, tau_d;
  logic [15:0] u_q, u_d, w_q, w_d;
  logic [AccW-1:0] num_q, num_d, p_q, p_d;
  logic [63:0] lim_q, lim_d;
  logic [1:0]  n_q, n_d, k_q, k_d;
  logic [4:0]  bit_q, bit_d;
  result_t     res_q, res_d;

  logic            mul_start, mul_done;
  logic [AccW-1:0] mul_a, mul_res;
  logic [31:0]     mul_m, cand, tf, tt;
  logic [63:0]     g;
  logic [AccW-1:0] num15, numka;

  qtp_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .m_i     (mul_m),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q  <= '0;
      acc_q  <= '0;
      jerk_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_VEL:  vel_q  <= cfg_wdata_i;
        CFG_ACC:  acc_q  <= cfg_wdata_i;
        CFG_JERK: jerk_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // state and plan memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      sdist_q <= '0;
      sdur_q  <= '0;
      n_q     <= '0;
      k_q     <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      sdist_q <= sdist_d;
      sdur_q  <= sdur_d;
      n_q     <= n_d;
      k_q     <= k_d;
      bit_q   <= bit_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    t_q    <= t_d;
    x_q    <= x_d;
    tau_q  <= tau_d;
    u_q    <= u_d;
    w_q    <= w_d;
    num_q  <= num_d;
    p_q    <= p_d;
    lim_q  <= lim_d;
    res_q  <= res_d;
  end

  assign cand  = x_q | (32'd1 << bit_q);
  assign tf    = (t_q < MinDuration) ? MinDuration : t_q;
  assign tt    = {16'd0, tau_q[15:0]};
  assign num15 = {79'd0, mul15(mag_q), 13'd0};
  assign numka = {61'd0, mul_ka(mag_q), 16'd0};
  // 10 - 15t + 6t^2 scaled by 2^32
  assign g = (64'd10 << 32) + ({32'd0, p_q[31:0]} << 2) + ({32'd0, p_q[31:0]} << 1)
           - ({47'd0, tau_q} << 20) + ({47'd0, tau_q} << 16);

  // sequencer
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    sdist_d = sdist_q;
    sdur_d  = sdur_q;
    dist_d  = dist_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    t_d     = t_q;
    x_d     = x_q;
    tau_d   = tau_q;
    u_d     = u_q;
    w_d     = w_q;
    num_d   = num_q;
    p_d     = p_q;
    lim_d   = lim_q;
    n_d     = n_q;
    k_d     = k_q;
    bit_d   = bit_q;
    res_d   = res_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_m     = '0;
    done_o    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_d  = '0;
          dist_d = move_distance_i;
          mag_d  = abs32(move_distance_i);
          tau_d  = norm_time_i;
          state_d = (op_e'(opcode_i) == OP_PLAN) ? ST_PLAN : ST_SAMP;
        end
      end
      // plan: zero distance clears the stored move
      ST_PLAN: begin
        t_d = '0;
        if (dist_q == 32'd0) begin
          sdist_d = '0;
          sdur_d  = '0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_PV;
        end
      end
      ST_PV: begin
        if (vel_q != 32'd0) begin
          num_d = num15; lim_d = {32'd0, vel_q}; n_d = 2'd1;
          x_d = '0; bit_d = 5'd31; ret_d = ST_PVR; state_d = ST_FTRY;
        end else begin
          state_d = ST_PA;
        end
      end
      ST_PVR: begin
        if (x_q > t_q) t_d = x_q;
        state_d = ST_PA;
      end
      ST_PA: begin
        if (acc_q != 32'd0) begin
          num_d = numka; lim_d = {32'd0, acc_q}; n_d = 2'd2;
          x_d = '0; bit_d = 5'd31; ret_d = ST_PAR; state_d = ST_FTRY;
        end else begin
          state_d = ST_PJ;
        end
      end
      ST_PAR: begin
        if (x_q > t_q) t_d = x_q;
        state_d = ST_PJ;
      end
      ST_PJ: begin
        if (jerk_q != 32'd0) begin
          num_d = {42'd0, mul60(mag_q), 48'd0}; lim_d = {32'd0, jerk_q}; n_d = 2'd3;
          x_d = '0; bit_d = 5'd31; ret_d = ST_PJR; state_d = ST_FTRY;
        end else begin
          state_d = ST_PF;
        end
      end
      ST_PJR: begin
        if (x_q > t_q) t_d = x_q;
        state_d = ST_PF;
      end
      // duration floor, store the plan, peak speed
      ST_PF: begin
        t_d     = tf;
        sdist_d = dist_q;
        sdur_d  = tf;
        res_d.move_duration = tf;
        num_d = num15; lim_d = {32'd0, tf}; n_d = 2'd1;
        x_d = '0; bit_d = 5'd31; ret_d = ST_P1R; state_d = ST_FTRY;
      end
      ST_P1R: begin
        res_d.peak_velocity = x_q;
        mul_start = 1'b1; mul_a = {96'd0, t_q}; mul_m = t_q;
        ret_d = ST_P2; state_d = ST_MW;
      end
      ST_P2: begin
        num_d = numka; lim_d = p_q[63:0]; n_d = 2'd1;
        x_d = '0; bit_d = 5'd31; ret_d = ST_P2R; state_d = ST_FTRY;
      end
      ST_P2R: begin
        res_d.peak_acceleration = x_q;
        state_d = ST_DONE;
      end
      // sample: no stored plan or special times end early
      ST_SAMP: begin
        neg_d = sdist_q[31];
        mag_d = abs32(sdist_q);
        u_d   = 16'(17'h1_0000 - tau_q);
        w_d   = tau_q[15] ? 16'((tau_q << 1) - 18'h1_0000) : 16'(18'h1_0000 - (tau_q << 1));
        if (sdur_q == 32'd0) begin
          state_d = ST_DONE;
        end else if (tau_q[16]) begin
          res_d.ref_position = sdist_q;
          state_d = ST_DONE;
        end else if (tau_q == 17'd0) begin
          state_d = ST_DONE;
        end else begin
          mul_start = 1'b1; mul_a = {96'd0, tt}; mul_m = tt;
          ret_d = ST_SG; state_d = ST_MW;
        end
      end
      ST_SG: begin
        mul_start = 1'b1; mul_a = {64'd0, g}; mul_m = tt;
        ret_d = ST_SP1; state_d = ST_MW;
      end
      ST_SP1: begin
        mul_start = 1'b1; mul_a = p_q; mul_m = tt;
        ret_d = ST_SP2; state_d = ST_MW;
      end
      ST_SP2: begin
        mul_start = 1'b1; mul_a = p_q; mul_m = tt;
        ret_d = ST_SP3; state_d = ST_MW;
      end
      ST_SP3: begin
        mul_start = 1'b1; mul_a = p_q; mul_m = mag_q;
        ret_d = ST_SP4; state_d = ST_MW;
      end
      ST_SP4: begin
        res_d.ref_position = sat_signed(p_q[127:80], neg_q);
        mul_start = 1'b1; mul_a = {91'd0, mul30(mag_q)}; mul_m = tt;
        ret_d = ST_SV1; state_d = ST_MW;
      end
      ST_SV1: begin
        mul_start = 1'b1; mul_a = p_q; mul_m = tt;
        ret_d = ST_SV2; state_d = ST_MW;
      end
      ST_SV2: begin
        mul_start = 1'b1; mul_a = p_q; mul_m = {16'd0, u_q};
        ret_d = ST_SV3; state_d = ST_MW;
      end
      ST_SV3: begin
        mul_start = 1'b1; mul_a = p_q; mul_m = {16'd0, u_q};
        ret_d = ST_SV4; state_d = ST_MW;
      end
      ST_SV4: begin
        num_d = {48'd0, p_q[127:48]}; lim_d = {32'd0, sdur_q}; n_d = 2'd1;
        x_d = '0; bit_d = 5'd31; ret_d = ST_SV5; state_d = ST_FTRY;
      end
      ST_SV5: begin
        res_d.ref_velocity = sat_signed({16'd0, x_q}, neg_q);
        mul_start = 1'b1; mul_a = {90'd0, mul60(mag_q)}; mul_m = tt;
        ret_d = ST_SA1; state_d = ST_MW;
      end
      ST_SA1: begin
        mul_start = 1'b1; mul_a = p_q; mul_m = {16'd0, w_q};
        ret_d = ST_SA2; state_d = ST_MW;
      end
      ST_SA2: begin
        mul_start = 1'b1; mul_a = p_q; mul_m = {16'd0, u_q};
        ret_d = ST_SA3; state_d = ST_MW;
      end
      ST_SA3: begin
        num_d = {16'd0, p_q[127:16]};
        mul_start = 1'b1; mul_a = {96'd0, sdur_q}; mul_m = sdur_q;
        ret_d = ST_SA4; state_d = ST_MW;
      end
      ST_SA4: begin
        lim_d = p_q[63:0]; n_d = 2'd1;
        x_d = '0; bit_d = 5'd31; ret_d = ST_SA5; state_d = ST_FTRY;
      end
      ST_SA5: begin
        res_d.ref_acceleration = sat_signed({16'd0, x_q},
                                            (tau_q > 17'd32768) ? !neg_q : neg_q);
        state_d = ST_DONE;
      end
      // plain multiply, result into p
      ST_MW: begin
        if (mul_done) begin
          p_d = mul_res;
          state_d = ret_q;
        end
      end
      // bound search: one result bit per trial of lim * cand^n against num
      ST_FTRY: begin
        mul_start = 1'b1; mul_a = {64'd0, lim_q}; mul_m = cand;
        k_d = 2'd1; state_d = ST_FMW;
      end
      ST_FMW: begin
        if (mul_done) begin
          if (k_q < n_q) begin
            mul_start = 1'b1; mul_a = mul_res; mul_m = cand;
            k_d = k_q + 2'd1;
          end else begin
            if (mul_res <= num_q) x_d = cand;
            if (bit_q == 5'd0) begin
              state_d = ret_q;
            end else begin
              bit_d = bit_q - 5'd1;
              state_d = ST_FTRY;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);
  assign res_o  = res_q;

  // the multiplier never reports done right after a start
  assert property (@(posedge clk_i) disable iff (!rst_ni) mul_start |=> !mul_done)
    else $error("multiplier finished right after start");
  // trial product count stays within the power being searched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FMW && mul_done) |-> (k_q != 2'd0 && k_q <= n_q))
    else $error("trial multiply count out of range");
  // a stored plan never has a duration below the floor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sdur_q != 32'd0) |-> (sdur_q >= MinDuration))
    else $error("stored duration below floor");

endmodule

[design/quintic_trajectory_planner.sv]
// quintic_trajectory_planner: top level, stream handshake and result register
// depends on qtp_pkg and qtp_core
//
// Usage
//   Input stream: s_axis_tuser is the opcode (plan or sample), s_axis_tdata
//   carries the signed move distance (Q16.16) and normalized time (Q1.16).
//   A plan request stores the move and its minimum duration from the
//   velocity, acceleration and jerk limits; a sample request evaluates the
//   stored quintic at the given time. Each request gives one result on the
//   output stream, all six fields at once, unused fields zero.
//   Limits are written through cfg_we_i / cfg_index_i / cfg_wdata_i; the user
//   must write them only while idle, the block itself does not enforce it.
// Arithmetic
//   One request at a time. The variable products run through one shared
//   bit-serial multiplier; the bounds are found by a 32-step trial search.
//   Special times and zero distance skip the arithmetic.
// Reset
//   Clears limits and the stored plan; samples then return zeros.
// Stall
//   The result waits in the output register; the next request is taken
//   meanwhile, and its result waits in the sequencer until the register frees.
module quintic_trajectory_planner import qtp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // move_distance[31:0], norm_time[48:32], zero pad
  input  logic         s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // move_duration, peak_velocity, peak_acceleration, ref_position,
  // ref_velocity, ref_acceleration, 32 bits each from bit 0 up
  output logic [191:0] m_axis_tdata
);

  logic    core_idle, core_done, out_free;
  result_t core_res;
  logic    m_valid_q;
  result_t m_data_q;

  assign s_axis_tready = core_idle;
  assign out_free      = !m_valid_q || m_axis_tready;

  qtp_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_i         (s_axis_tvalid && core_idle),
    .opcode_i        (s_axis_tuser),
    .move_distance_i (s_axis_tdata[31:0]),
    .norm_time_i     (s_axis_tdata[48:32]),
    .out_free_i      (out_free),
    .idle_o          (core_idle),
    .done_o          (core_done),
    .res_o           (core_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (core_done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) m_data_q <= core_res;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[tb/sv/qtp_checker.sv]
// qtp_checker: watches the config port and both streams of the trajectory planner,
// predicts each result and compares it field by field; depends on qtp_pkg
`timescale 1ns / 1ps

module qtp_checker import qtp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // move_distance[31:0], norm_time[48:32], zero pad
  input  logic         s_axis_tuser,  // opcode
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // move_duration, peak_velocity, peak_acceleration, ref_position,
  // ref_velocity, ref_acceleration, 32 bits each from bit 0 up
  input  logic [191:0] m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);

  localparam logic [31:0] KaQ16 = 32'd378372;

  logic [31:0] vel_lim, acc_lim, jerk_lim;
  logic [31:0] plan_dist, plan_dur;
  result_t     expected_q[$];

  // largest x < 2^32 with x^n * lim <= num
  function automatic logic [31:0] largest_fit(input int n, input logic [63:0] lim,
                                              input logic [127:0] num);
    logic [31:0]  x;
    logic [31:0]  c;
    logic [255:0] p;
    x = '0;
    for (int b = 31; b >= 0; b--) begin
      c = x | (32'd1 << b);
      p = {192'd0, lim};
      for (int i = 0; i < n; i++) p = p * {224'd0, c};
      if (p <= {128'd0, num}) x = c;
    end
    return x;
  endfunction

  function automatic logic [31:0] clamp_signed(input logic [127:0] mag, input logic neg);
    if (!neg) return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    if (mag > 128'h8000_0000) mag = 128'h8000_0000;
    return 32'd0 - mag[31:0];
  endfunction

  // expected result of one request; updates the stored plan
  function automatic result_t plan_or_sample(input op_e op, input logic [31:0] move_dist,
                                             input logic [16:0] tau);
    result_t      r;
    logic [127:0] mag, tt, u, w, g, p, dur;
    logic [31:0]  t, c;
    logic         neg;
    r = '0;
    if (op == OP_PLAN) begin
      mag = {96'd0, abs32(move_dist)};
      if (move_dist == 0) begin
        plan_dist = '0;
        plan_dur  = '0;
        return r;
      end
      t = '0;
      if (vel_lim != 0) begin
        c = largest_fit(1, {32'd0, vel_lim}, (mag * 15) << 13);
        if (c > t) t = c;
      end
      if (acc_lim != 0) begin
        c = largest_fit(2, {32'd0, acc_lim}, (mag * KaQ16) << 16);
        if (c > t) t = c;
      end
      if (jerk_lim != 0) begin
        c = largest_fit(3, {32'd0, jerk_lim}, (mag * 60) << 48);
        if (c > t) t = c;
      end
      if (t < MinDuration) t = MinDuration;
      plan_dist = move_dist;
      plan_dur  = t;
      r.move_duration     = t;
      r.peak_velocity     = largest_fit(1, {32'd0, t}, (mag * 15) << 13);
      r.peak_acceleration = largest_fit(1, {32'd0, t} * {32'd0, t}, (mag * KaQ16) << 16);
      return r;
    end
    // sample of the stored quintic
    if (plan_dur == 0) return r;
    neg = plan_dist[31];
    mag = {96'd0, abs32(plan_dist)};
    dur = {96'd0, plan_dur};
    if (tau >= 17'd65536) begin
      r.ref_position = plan_dist;
    end else if (tau != 0) begin
      tt = {111'd0, tau};
      u  = 128'd65536 - tt;
      w  = (tt >= 32768) ? (2 * tt - 65536) : (65536 - 2 * tt);
      g  = (128'd10 << 32) + 6 * tt * tt - 983040 * tt;
      p  = g * tt * tt * tt * mag;
      r.ref_position = clamp_signed(p >> 80, neg);
      p  = 30 * mag * tt * tt * u * u;
      r.ref_velocity = clamp_signed({96'd0, largest_fit(1, dur[63:0], p >> 48)}, neg);
      p  = 60 * mag * tt * w * u;
      r.ref_acceleration = clamp_signed({96'd0, largest_fit(1, dur[63:0] * dur[63:0],
                                                            p >> 16)},
                                        (tt > 32768) ? !neg : neg);
    end
    return r;
  endfunction

  // track limit writes, predict requests, check results
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    result_t got;
    if (!rst_ni) begin
      vel_lim      <= '0;
      acc_lim      <= '0;
      jerk_lim     <= '0;
      plan_dist    = '0;
      plan_dur     = '0;
      fail_count_o <= 0;
      expected_q.delete();
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_VEL:  vel_lim  <= cfg_wdata_i;
          CFG_ACC:  acc_lim  <= cfg_wdata_i;
          CFG_JERK: jerk_lim <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(plan_or_sample(op_e'(s_axis_tuser), s_axis_tdata[31:0],
                                            s_axis_tdata[48:32]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got != exp_r) fail_count_o <= fail_count_o + 1;
          if (got.move_duration != exp_r.move_duration)
            $error("move_duration exp %h got %h", exp_r.move_duration, got.move_duration);
          if (got.peak_velocity != exp_r.peak_velocity)
            $error("peak_velocity exp %h got %h", exp_r.peak_velocity, got.peak_velocity);
          if (got.peak_acceleration != exp_r.peak_acceleration)
            $error("peak_acceleration exp %h got %h", exp_r.peak_acceleration,
                   got.peak_acceleration);
          if (got.ref_position != exp_r.ref_position)
            $error("ref_position exp %h got %h", exp_r.ref_position, got.ref_position);
          if (got.ref_velocity != exp_r.ref_velocity)
            $error("ref_velocity exp %h got %h", exp_r.ref_velocity, got.ref_velocity);
          if (got.ref_acceleration != exp_r.ref_acceleration)
            $error("ref_acceleration exp %h got %h", exp_r.ref_acceleration,
                   got.ref_acceleration);
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
// tb_top: stimulus, idling and verdict for quintic_trajectory_planner
// depends on qtp_pkg, qtp_checker and the planner rtl
`timescale 1ns / 1ps

module tb_top;
  import qtp_pkg::*;

  localparam int WatchdogLimit = 200000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata = '0;  // move_distance[31:0], norm_time[48:32], zero pad
  logic         s_axis_tuser = 1'b0;  // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // move_duration, peak_velocity, peak_acceleration, ref_position,
  // ref_velocity, ref_acceleration, 32 bits each from bit 0 up
  logic [191:0] m_axis_tdata;
  int           fail_count, pending;
  bit           idling = 1'b1;
  int           stall_left = 0;
  int           quiet_cycles = 0;

  quintic_trajectory_planner dut (.*);

  qtp_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure, one stall draw per result
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      stall_left = idling ? $urandom_range(12, 0) : 0;
      m_axis_tready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= (stall_left == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else if (rst_ni && ++quiet_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(input op_e op, input logic [31:0] move_dist,
                              input logic [16:0] tau);
    int gap;
    gap = idling ? $urandom_range(12, 0) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, tau, move_dist};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // limits change only once every result is back
  task automatic set_limits(input logic [31:0] v, input logic [31:0] a,
                            input logic [31:0] j);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_VEL;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_index_i <= CFG_ACC;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_index_i <= CFG_JERK;
    cfg_wdata_i <= j;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_distance();
    case ($urandom_range(4, 0))
      0: return $urandom_range(1 << 16, 1);
      1: return 32'd0 - $urandom_range(1 << 20, 1);
      2: return $urandom;
      3: return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom_range(1 << 24, 1) << $urandom_range(7, 0);
    endcase
  endfunction

  function automatic logic [16:0] rand_time();
    case ($urandom_range(9, 0))
      0: return 17'd0;
      1: return 17'($urandom_range(131071, 65536));
      2: return 17'(17'd32768 + $urandom_range(2, 0) - 1);
      default: return 17'($urandom_range(65535, 1));
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 20) idling = ~idling;
      if ($urandom_range(9, 0) < 3)
        send_request(OP_PLAN, ($urandom_range(30, 0) == 0) ? 32'd0 : rand_distance(), '0);
      else
        send_request(OP_SAMPLE, $urandom, rand_time());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no plan, all limits zero, special times, zero distance
    send_request(OP_SAMPLE, 32'hFFFF_FFFF, 17'd40000);
    send_request(OP_PLAN, 32'h0001_0000, '0);
    send_request(OP_SAMPLE, '0, 17'd0);
    send_request(OP_SAMPLE, '0, 17'd1);
    send_request(OP_SAMPLE, '0, 17'd32768);
    send_request(OP_SAMPLE, '0, 17'd65535);
    send_request(OP_SAMPLE, '0, 17'd65536);
    send_request(OP_SAMPLE, '0, 17'h1FFFF);
    send_request(OP_PLAN, 32'd0, '0);
    send_request(OP_SAMPLE, '0, 17'd20000);

    // extremes of the limits and distances
    set_limits(32'd1, 32'd1, 32'd1);
    send_request(OP_PLAN, 32'h7FFF_FFFF, '0);
    send_request(OP_SAMPLE, '0, 17'd10000);
    send_request(OP_PLAN, 32'h8000_0000, '0);
    send_request(OP_SAMPLE, '0, 17'd50000);
    send_request(OP_SAMPLE, '0, 17'd65536);
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_PLAN, 32'hFFFF_FFFF, '0);
    send_request(OP_SAMPLE, '0, 17'd30000);
    send_request(OP_PLAN, 32'h7FFF_FFFF, '0);
    send_request(OP_SAMPLE, '0, 17'd45000);

    // unused register index is ignored
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_NONE;
    cfg_wdata_i <= 32'h0000_0001;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_request(OP_PLAN, 32'h0100_0000, '0);

    // random phases over several limit settings
    set_limits(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
    random_phase(150);
    set_limits(32'h0010_0000, 32'd0, 32'd0);
    random_phase(150);
    set_limits(32'd0, $urandom_range(32'h0010_0000, 1), 32'd0);
    random_phase(150);
    set_limits(32'd0, 32'd0, $urandom);
    random_phase(150);
    set_limits($urandom, $urandom, $urandom);
    random_phase(150);
    set_limits(32'd0, 32'd0, 32'd0);
    random_phase(180);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
